// ----- rtl/core/multi_stack_shared_buffer_assert.svh -----
// assertion macros, sampled on clk, off while rst_n is low
`ifndef MULTI_STACK_SHARED_BUFFER_ASSERT_SVH
`define MULTI_STACK_SHARED_BUFFER_ASSERT_SVH

// consequent holds in the same cycle
`define MSB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define MSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/msb_pkg.sv -----
`default_nettype none

package msb_pkg;

  localparam int NUM_STACKS_DEF = 8;
  localparam int CAPACITY_DEF   = 256;

  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic val_we;
  } store_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/msb_store.sv -----
`default_nettype none

module msb_store #(
  parameter int CAPACITY = msb_pkg::CAPACITY_DEF,
  parameter int PTR_W    = $clog2(CAPACITY + 1),
  parameter int AW       = $clog2(CAPACITY)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire msb_pkg::store_ctl_t       ctl,
  input  wire logic [AW-1:0]             rd_addr,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [PTR_W-1:0]          link_wdata,
  input  wire logic [msb_pkg::DATA_W-1:0] val_wdata,
  output logic      [PTR_W-1:0]          link_rdata,
  output logic      [msb_pkg::DATA_W-1:0] val_rdata
);

  logic [PTR_W-1:0]           link_mem [CAPACITY];
  logic [msb_pkg::DATA_W-1:0] val_mem  [CAPACITY];

  logic [PTR_W-1:0] link_q;
  logic [AW-1:0]    rd_addr_r;
  logic [PTR_W-1:0] fill_r;
  logic [PTR_W-1:0] fill_nxt;

  // entries at or above the fill mark read back the link i+1 in place of memory
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      link_q    <= link_mem[rd_addr];
      val_rdata <= val_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (ctl.link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
    if (ctl.val_we) begin
      val_mem[wr_addr] <= val_wdata;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.link_we && (PTR_W'(wr_addr) == fill_r)) begin
      fill_nxt = fill_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign link_rdata = (PTR_W'(rd_addr_r) >= fill_r) ? PTR_W'(rd_addr_r) + PTR_W'(1) : link_q;

endmodule

`default_nettype wire

// ----- rtl/core/multi_stack_shared_buffer.sv -----
// multi_stack_shared_buffer: several lifo stacks kept as linked lists in one
// shared store, with a shared free list of entries
// input channel in_valid/in_ready carries one word: in_func (0 push, 1 pop),
// in_stack_index and in_push_value; every word gives exactly one result
// result channel out_valid/out_ready carries out_status (0 ok, 1 full,
// 2 empty) and out_pop_value (popped value, -1 on empty pop, 0 on push)
// result: an accepted word moves the block to its exec state, which then sets
// the out_valid register; the block takes no new word while one is in work;
// the pointer for the word is read from flops, then link and value come from
// the synchronous store memories and are written back in the exec state
// reset: all stacks empty, free list runs through every entry in order,
// no clearing pass is needed; the block takes input right after reset
// stall: a waiting result is held in the output register; one new word is
// accepted while it waits only if out_ready takes the result in that cycle
`default_nettype none

module multi_stack_shared_buffer #(
  parameter int NUM_STACKS = msb_pkg::NUM_STACKS_DEF,
  parameter int CAPACITY   = msb_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_func,
  input  wire logic [msb_pkg::IDX_W-1:0]   in_stack_index,
  input  wire logic [msb_pkg::DATA_W-1:0]  in_push_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [msb_pkg::STAT_W-1:0]  out_status,
  output logic      [msb_pkg::DATA_W-1:0]  out_pop_value
);

  `include "multi_stack_shared_buffer_assert.svh"

  localparam int PTR_W  = $clog2(CAPACITY + 1);
  localparam int AW     = $clog2(CAPACITY);
  localparam int MAX_IX = 1 << msb_pkg::IDX_W;
  localparam int TOP_N  = (NUM_STACKS < MAX_IX) ? NUM_STACKS : MAX_IX;
  localparam int TOP_AW = (TOP_N > 1) ? $clog2(TOP_N) : 1;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic func_r, func_nxt;
  logic ok_r, ok_nxt;
  logic [TOP_AW-1:0]          idx_r, idx_nxt;
  logic [msb_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [PTR_W-1:0]           slot_r, slot_nxt;
  logic [PTR_W-1:0]           free_head_r, free_head_nxt;
  logic [PTR_W-1:0]           top_r [TOP_N];
  logic [PTR_W-1:0]           top_nxt [TOP_N];
  logic                       out_valid_r, out_valid_nxt;
  logic [msb_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [msb_pkg::DATA_W-1:0] out_pop_value_r, out_pop_value_nxt;

  logic                       accept;
  logic                       in_range;
  logic [TOP_AW-1:0]          idx_a;
  logic [PTR_W-1:0]           slot_sel;
  msb_pkg::store_ctl_t        ctl;
  logic [PTR_W-1:0]           link_wdata;
  logic [PTR_W-1:0]           link_rdata;
  logic [msb_pkg::DATA_W-1:0] val_rdata;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign in_range  = int'(in_stack_index) < NUM_STACKS;
  assign idx_a     = TOP_AW'(in_stack_index);
  assign slot_sel  = (in_func == msb_pkg::FUNC_PUSH) ? free_head_r : top_r[idx_a];
  assign link_wdata = (func_r == msb_pkg::FUNC_PUSH) ? top_r[idx_r] : free_head_r;

  always_comb begin
    ctl.rd_en   = accept;
    ctl.link_we = (state_r == S_EXEC) && ok_r;
    ctl.val_we  = (state_r == S_EXEC) && ok_r && (func_r == msb_pkg::FUNC_PUSH);
  end

  msb_store #(
    .CAPACITY (CAPACITY),
    .PTR_W    (PTR_W),
    .AW       (AW)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_addr    (slot_sel[AW-1:0]),
    .wr_addr    (slot_r[AW-1:0]),
    .link_wdata (link_wdata),
    .val_wdata  (val_r),
    .link_rdata (link_rdata),
    .val_rdata  (val_rdata)
  );

  always_comb begin
    state_nxt         = state_r;
    func_nxt          = func_r;
    ok_nxt            = ok_r;
    idx_nxt           = idx_r;
    val_nxt           = val_r;
    slot_nxt          = slot_r;
    free_head_nxt     = free_head_r;
    top_nxt           = top_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_status_nxt    = out_status_r;
    out_pop_value_nxt = out_pop_value_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
          func_nxt  = in_func;
          idx_nxt   = idx_a;
          val_nxt   = in_push_value;
          slot_nxt  = slot_sel;
          ok_nxt    = in_range && (slot_sel != NULL_PTR);
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (func_r == msb_pkg::FUNC_PUSH) begin
          out_pop_value_nxt = '0;
          if (ok_r) begin
            out_status_nxt = msb_pkg::ST_OK;
            free_head_nxt  = link_rdata;
            top_nxt[idx_r] = slot_r;
          end else begin
            out_status_nxt = msb_pkg::ST_FULL;
          end
        end else begin
          if (ok_r) begin
            out_status_nxt    = msb_pkg::ST_OK;
            out_pop_value_nxt = val_rdata;
            top_nxt[idx_r]    = link_rdata;
            free_head_nxt     = slot_r;
          end else begin
            out_status_nxt    = msb_pkg::ST_EMPTY;
            out_pop_value_nxt = '1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_head_r <= '0;
      for (int i = 0; i < TOP_N; i++) begin
        top_r[i] <= NULL_PTR;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_head_r <= free_head_nxt;
      top_r       <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r          <= func_nxt;
    ok_r            <= ok_nxt;
    idx_r           <= idx_nxt;
    val_r           <= val_nxt;
    slot_r          <= slot_nxt;
    out_status_r    <= out_status_nxt;
    out_pop_value_r <= out_pop_value_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_pop_value = out_pop_value_r;

  `MSB_ASSERT_NEXT(a_accept_exec, accept, state_r == S_EXEC)
  `MSB_ASSERT_NEXT(a_exec_result, state_r == S_EXEC, out_valid_r)
  `MSB_ASSERT_SAME(a_empty_value, out_valid_r && (out_status_r == msb_pkg::ST_EMPTY),
                   out_pop_value_r == '1)
  `MSB_ASSERT_SAME(a_free_range, 1'b1, free_head_r <= NULL_PTR)

endmodule

`default_nettype wire

// ----- verif/multi_stack_shared_buffer_test.sv -----
module multi_stack_shared_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTK = msb_pkg::NUM_STACKS_DEF;
  localparam int CAP = msb_pkg::CAPACITY_DEF;
  localparam int PTR_W = $clog2(CAP + 1);
  localparam logic [PTR_W-1:0] NO_ENTRY = PTR_W'(CAP);
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [msb_pkg::STAT_W-1:0] status;
    logic [msb_pkg::DATA_W-1:0] pop_value;
  } stack_reply_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_func;
  logic [msb_pkg::IDX_W-1:0] in_stack_index;
  logic [msb_pkg::DATA_W-1:0] in_push_value;
  logic out_valid;
  logic out_ready;
  logic [msb_pkg::STAT_W-1:0] out_status;
  logic [msb_pkg::DATA_W-1:0] out_pop_value;

  multi_stack_shared_buffer u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_stack_index(in_stack_index),
    .in_push_value(in_push_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_pop_value(out_pop_value)
  );

  // shadow copy of the linked stacks and the free list
  logic [PTR_W-1:0] top_entry [NSTK];
  logic [PTR_W-1:0] next_entry [CAP];
  logic [msb_pkg::DATA_W-1:0] entry_value [CAP];
  logic [PTR_W-1:0] free_first;

  stack_reply_t pending_replies[$];
  int error_count;
  int words_sent;
  int pops_with_data;
  int full_pushes;
  int empty_pops;
  int quiet_cycles;
  int reply_stall;
  bit idle_on;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void clear_stacks();
    for (int i = 0; i < NSTK; i++) top_entry[i] = NO_ENTRY;
    for (int i = 0; i < CAP; i++) begin
      next_entry[i] = (i == CAP - 1) ? NO_ENTRY : PTR_W'(i + 1);
      entry_value[i] = '0;
    end
    free_first = '0;
  endfunction

  function automatic stack_reply_t apply_stack_op(input logic func,
                                                  input logic [msb_pkg::IDX_W-1:0] idx,
                                                  input logic [msb_pkg::DATA_W-1:0] value);
    stack_reply_t reply;
    logic [PTR_W-1:0] slot;
    reply.status = msb_pkg::ST_OK;
    reply.pop_value = '0;
    if (func == msb_pkg::FUNC_PUSH) begin
      if (int'(idx) >= NSTK || free_first == NO_ENTRY) begin
        reply.status = msb_pkg::ST_FULL;
        full_pushes++;
      end else begin
        slot = free_first;
        entry_value[slot] = value;
        free_first = next_entry[slot];
        next_entry[slot] = top_entry[idx];
        top_entry[idx] = slot;
      end
    end else begin
      slot = (int'(idx) < NSTK) ? top_entry[idx] : NO_ENTRY;
      if (slot == NO_ENTRY) begin
        reply.status = msb_pkg::ST_EMPTY;
        reply.pop_value = '1;
        empty_pops++;
      end else begin
        top_entry[idx] = next_entry[slot];
        next_entry[slot] = free_first;
        free_first = slot;
        reply.pop_value = entry_value[slot];
        pops_with_data++;
      end
    end
    return reply;
  endfunction

  task automatic send_word(input logic func, input logic [msb_pkg::IDX_W-1:0] idx,
                           input logic [msb_pkg::DATA_W-1:0] value);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_stack_index <= idx;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(apply_stack_op(func, idx, value));
    words_sent++;
  endtask

  task automatic wait_for_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_ops(input int count, input int push_pct);
    for (int i = 0; i < count; i++) begin
      send_word(($urandom_range(0, 99) < push_pct) ? msb_pkg::FUNC_PUSH : msb_pkg::FUNC_POP,
                msb_pkg::IDX_W'($urandom_range(0, NSTK - 1)), $urandom);
    end
  endtask

  task automatic test_empty_after_reset();
    send_word(msb_pkg::FUNC_POP, '0, 32'h1234_5678);
    send_word(msb_pkg::FUNC_POP, msb_pkg::IDX_W'(NSTK - 1), '1);
    wait_for_replies();
  endtask

  task automatic test_extreme_values();
    send_word(msb_pkg::FUNC_PUSH, 3'd0, 32'h7fff_ffff);
    send_word(msb_pkg::FUNC_PUSH, 3'd7, 32'h8000_0000);
    send_word(msb_pkg::FUNC_PUSH, 3'd3, 32'h0000_0000);
    send_word(msb_pkg::FUNC_PUSH, 3'd3, 32'hffff_ffff);
    send_word(msb_pkg::FUNC_POP, 3'd3, 32'h5555_5555);
    send_word(msb_pkg::FUNC_POP, 3'd3, 32'haaaa_aaaa);
    send_word(msb_pkg::FUNC_POP, 3'd3, '0);
    send_word(msb_pkg::FUNC_POP, 3'd7, '0);
    send_word(msb_pkg::FUNC_POP, 3'd0, '0);
    wait_for_replies();
  endtask

  task automatic test_stack_isolation();
    send_word(msb_pkg::FUNC_PUSH, 3'd1, 32'h0000_0011);
    send_word(msb_pkg::FUNC_PUSH, 3'd2, 32'h0000_0022);
    send_word(msb_pkg::FUNC_PUSH, 3'd1, 32'h0000_0111);
    send_word(msb_pkg::FUNC_POP, 3'd2, '0);
    send_word(msb_pkg::FUNC_POP, 3'd2, '0);
    send_word(msb_pkg::FUNC_POP, 3'd1, '0);
    send_word(msb_pkg::FUNC_POP, 3'd1, '0);
    wait_for_replies();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_random_ops(300, 50);
    wait_for_replies();
    idle_on = 1'b1;
  endtask

  task automatic test_fill_store();
    run_random_ops(400, 90);
    wait_for_replies();
  endtask

  task automatic test_drain_store();
    run_random_ops(400, 10);
    wait_for_replies();
  endtask

  task automatic test_mixed_traffic();
    run_random_ops(400, 55);
    wait_for_replies();
  endtask

  always @(posedge clk) begin
    stack_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word status %0d value %0h", $time, out_status, out_pop_value);
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_pop_value !== want.pop_value) begin
          error_count++;
          $display("%0t: pop_value expected %0h actual %0h", $time, want.pop_value,
                   out_pop_value);
        end
      end
      reply_stall = idle_on ? $urandom_range(0, 6) : 0;
    end
  end

  always @(negedge clk) begin
    out_ready <= (reply_stall == 0);
    if (reply_stall > 0) reply_stall--;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = msb_pkg::FUNC_PUSH;
    in_stack_index = '0;
    in_push_value = '0;
    out_ready = 1'b0;
    reply_stall = 0;
    quiet_cycles = 0;
    error_count = 0;
    words_sent = 0;
    pops_with_data = 0;
    full_pushes = 0;
    empty_pops = 0;
    idle_on = 1'b1;
    clear_stacks();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_after_reset();
    test_extreme_values();
    test_stack_isolation();
    test_back_to_back();
    test_fill_store();
    test_drain_store();
    test_mixed_traffic();

    repeat (10) @(posedge clk);
    $display("sent %0d push/pop words over %0d stacks sharing %0d entries", words_sent, NSTK,
             CAP);
    $display("%0d pops returned data, %0d pushes refused full, %0d pops refused empty",
             pops_with_data, full_pushes, empty_pops);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
